// ----- design/assert_macros.svh -----
// assertion macros shared by the census transform rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property that must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ----- design/mct3_pkg.sv -----
// types and constants of the 3x3 modified census transform
package mct3_pkg;

    localparam int PIX_W      = 8;
    localparam int CODE_W     = 9;
    localparam int POS_W      = 10;
    localparam int CFG_W      = 11;
    localparam int CFG_ADDR_W = 1;
    localparam int SUM_W      = 12;
    localparam int WIN_N      = 9;
    localparam int TDATA_O_W  = 32;
    localparam int MIN_DIM    = 3;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 11'd480;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_addr;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_meta;

endpackage

// ----- design/mct3_line_store.sv -----
// one row of pixel storage, one write and one registered read per cycle
module mct3_line_store
    import mct3_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_pix                     i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_pix                     o_rdata
);

    t_pix r_mem [DEPTH];
    t_pix r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/mct3_column_cell.sv -----
// one window column (top, middle, bottom pixel), handed on to the next cell
module mct3_column_cell
    import mct3_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_pix i_col [3],
    output t_pix o_col [3]
);

    t_pix r_col [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) r_col[k] <= '0;
        end else if (i_en) begin
            for (int k = 0; k < 3; k++) r_col[k] <= i_col[k];
        end
    end

    assign o_col = r_col;

endmodule

// ----- design/mct3_code_unit.sv -----
// window sum stage, then the compare stage into the output register
module mct3_code_unit
    import mct3_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_win_valid,
    input  t_pix              i_win [WIN_N],
    input  t_meta             i_meta,
    input  logic              i_out_ready,
    output logic              o_en,
    output logic              o_valid,
    output logic [CODE_W-1:0] o_code,
    output t_meta             o_meta
);

    logic              r_s1_valid;
    t_pix              r_s1_win [WIN_N];
    logic [SUM_W-1:0]  r_s1_sum;
    t_meta             r_s1_meta;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_code;
    t_meta             r_out_meta;

    logic [SUM_W-1:0]  n_sum;
    logic [CODE_W-1:0] n_code;

    // whole pipe moves together when the output register is free
    assign o_en = !r_out_valid || i_out_ready;

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < WIN_N; k++) n_sum = n_sum + SUM_W'(i_win[k]);
    end

    always_comb begin
        logic [SUM_W-1:0] nine_p;
        for (int k = 0; k < WIN_N; k++) begin
            nine_p    = (SUM_W'(r_s1_win[k]) << 3) + SUM_W'(r_s1_win[k]);
            n_code[k] = nine_p > r_s1_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_en) begin
            r_s1_valid  <= i_win_valid;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_s1_win   <= i_win;
            r_s1_sum   <= n_sum;
            r_s1_meta  <= i_meta;
            r_out_code <= n_code;
            r_out_meta <= r_s1_meta;
        end
    end

    assign o_valid = r_out_valid;
    assign o_code  = r_out_code;
    assign o_meta  = r_out_meta;

endmodule

// ----- design/modified_census_transform_3x3.sv -----
// Streaming 3x3 modified census transform. Takes one 8-bit pixel per clock in
// raster order and, once the current pixel sits at row >= 2 and column >= 2,
// returns a 9-bit code (bit k set when nine times window pixel k exceeds the
// window sum, k in raster order from top-left) with the center row, center
// column and a last flag on the frame's final window. Sustained rate is one
// pixel per clock; each window passes the sum stage register and the compare
// stage into the output register, and output back-pressure stalls the whole pipe.
// Two line stores of MAX_WIDTH bytes hold the previous rows; they come up
// undefined, have no clearing pass, and only rows already written are read.
// image_width and image_height clamp to 3..MAX_WIDTH / 3..MAX_HEIGHT and take
// effect at once; write them between frames.
module modified_census_transform_3x3
    import mct3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,  // [7:0] pixel
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [8:0] census_code, [18:9] center_row, [28:19] center_col, rest zero
    output logic [TDATA_O_W-1:0]  m_axis_tdata,
    output logic                  m_axis_tlast   // frame_last
);

`include "assert_macros.svh"

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int DIMW_W  = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int DIMH_W  = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

    logic [CFG_W-1:0]  r_image_width;
    logic [CFG_W-1:0]  r_image_height;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;

    logic [DIMW_W-1:0] w_ext;
    logic [DIMW_W-1:0] w_eff;
    logic [DIMH_W-1:0] h_ext;
    logic [DIMH_W-1:0] h_eff;
    logic              row_end;
    logic              frame_end;
    logic              accept;
    logic              pipe_en;
    logic              win_valid;
    logic [COL_W-1:0]  col_m1;
    logic [ROW_W-1:0]  row_m1;
    logic [COL_W-1:0]  raddr;

    t_pix  top_px;
    t_pix  mid_px;
    t_pix  new_col [3];
    t_pix  col_c1  [3];
    t_pix  col_c2  [3];
    t_pix  win     [WIN_N];
    t_meta win_meta;
    t_meta out_meta;
    logic [CODE_W-1:0] out_code;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        w_ext = DIMW_W'(r_image_width);
        h_ext = DIMH_W'(r_image_height);
        if (w_ext < DIMW_W'(MIN_DIM))        w_eff = DIMW_W'(MIN_DIM);
        else if (w_ext > DIMW_W'(MAX_WIDTH)) w_eff = DIMW_W'(MAX_WIDTH);
        else                                 w_eff = w_ext;
        if (h_ext < DIMH_W'(MIN_DIM))         h_eff = DIMH_W'(MIN_DIM);
        else if (h_ext > DIMH_W'(MAX_HEIGHT)) h_eff = DIMH_W'(MAX_HEIGHT);
        else                                  h_eff = h_ext;
    end

    assign row_end   = (DIMW_W'(r_col) + DIMW_W'(1)) >= w_eff;
    assign frame_end = (DIMH_W'(r_row) + DIMH_W'(1)) >= h_eff;
    assign accept    = s_axis_tvalid && pipe_en;
    assign s_axis_tready = pipe_en;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (row_end) begin
                n_col = '0;
                n_row = frame_end ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // read ahead at the next pixel's column so data is ready on its request
    assign raddr = n_col;

    mct3_line_store #(.DEPTH(MAX_WIDTH)) u_store_upper (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (mid_px),
        .i_raddr (raddr),
        .o_rdata (top_px)
    );

    mct3_line_store #(.DEPTH(MAX_WIDTH)) u_store_middle (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (s_axis_tdata),
        .i_raddr (raddr),
        .o_rdata (mid_px)
    );

    assign new_col[0] = top_px;
    assign new_col[1] = mid_px;
    assign new_col[2] = s_axis_tdata;

    mct3_column_cell u_cell_c1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_col   (new_col),
        .o_col   (col_c1)
    );

    mct3_column_cell u_cell_c2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_col   (col_c1),
        .o_col   (col_c2)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win[3*k]     = col_c2[k];
            win[3*k + 1] = col_c1[k];
            win[3*k + 2] = new_col[k];
        end
    end

    assign col_m1    = r_col - COL_W'(1);
    assign row_m1    = r_row - ROW_W'(1);
    assign win_valid = accept && (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));

    always_comb begin
        win_meta.row  = POS_W'(row_m1);
        win_meta.col  = POS_W'(col_m1);
        win_meta.last = row_end && frame_end;
    end

    mct3_code_unit u_code (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win_valid (win_valid),
        .i_win       (win),
        .i_meta      (win_meta),
        .i_out_ready (m_axis_tready),
        .o_en        (pipe_en),
        .o_valid     (m_axis_tvalid),
        .o_code      (out_code),
        .o_meta      (out_meta)
    );

    assign m_axis_tdata = TDATA_O_W'({out_meta.col, out_meta.row, out_code});
    assign m_axis_tlast = out_meta.last;

    `ASSERT_PROP(a_col_wrap, i_clk, i_rst_n, accept && row_end |=> r_col == '0)
    `ASSERT_PROP(a_col_step, i_clk, i_rst_n, accept && !row_end |=> r_col == $past(r_col) + COL_W'(1))
    `ASSERT_PROP(a_hold_pos, i_clk, i_rst_n, !accept |=> $stable(r_col) && $stable(r_row))
    `ASSERT_NEVER(a_stall_cause, i_clk, i_rst_n, !s_axis_tready && !(m_axis_tvalid && !m_axis_tready))

endmodule

// ----- bench/tb.sv -----
// testbench for the 3x3 modified census transform: directed frames, then random frames
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mct3_pkg::*;

    localparam int MAX_W        = DEF_MAX_WIDTH;
    localparam int MAX_H        = DEF_MAX_HEIGHT;
    localparam int RANDOM_ITEMS = 380;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int PIPE_SLACK   = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 40;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic              last;
    } t_census;

    typedef enum logic {
        STEP_PIXEL,
        STEP_REG
    } t_step_kind;

    typedef struct {
        t_step_kind       kind;
        t_cfg_addr        addr;
        logic [CFG_W-1:0] value;
        bit               typed;
        t_census          want;
    } t_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata;   // [7:0] pixel
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [8:0] census_code, [18:9] center_row, [28:19] center_col, rest zero
    logic [TDATA_O_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;   // frame_last

    // predictor state
    logic [CFG_W-1:0] cfg_width  = RST_IMAGE_WIDTH;
    logic [CFG_W-1:0] cfg_height = RST_IMAGE_HEIGHT;
    t_pix             upper_row  [MAX_W];
    t_pix             middle_row [MAX_W];
    t_pix             prev2_col  [3] = '{8'd0, 8'd0, 8'd0};
    t_pix             prev1_col  [3] = '{8'd0, 8'd0, 8'd0};
    int               col_pos = 0;
    int               row_pos = 0;

    t_census pending_codes[$];
    int      mismatch_count = 0;
    int      codes_checked  = 0;
    int      pixels_taken   = 0;
    int      cycle_count    = 0;
    bit      steady         = 1'b0;
    bit      hold_done      = 1'b0;

    // window: row 1 center 255 gives bit 4; after the height cut the same pixel is top-middle
    t_step directed_steps [26] = '{
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    1'b0, '0},
        '{STEP_REG,   CFG_IMAGE_WIDTH,  11'd0,    1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    1'b0, '0},
        '{STEP_REG,   CFG_IMAGE_HEIGHT, 11'd2047, 1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255,  1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    1'b1, '{9'h010, 10'd1, 10'd1, 1'b0}},
        '{STEP_REG,   CFG_IMAGE_HEIGHT, 11'd2,    1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    1'b1, '{9'h002, 10'd2, 10'd1, 1'b1}},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255,  1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255,  1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255,  1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255,  1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255,  1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255,  1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255,  1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255,  1'b0, '0},
        '{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd255,  1'b1, '{9'h000, 10'd1, 10'd1, 1'b1}}
    };

    modified_census_transform_3x3 #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int eff_dim(input logic [CFG_W-1:0] v, input int hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    // advances the window by one pixel; returns 1 when a full window yields a code
    function automatic bit predict_census(input t_pix px, output t_census res);
        int   w;
        int   h;
        int   c;
        int   r;
        int   sum;
        t_pix top;
        t_pix mid;
        t_pix win [9];
        bit   row_end;
        bit   frame_end;
        bit   hit;
        w = eff_dim(cfg_width, MAX_W);
        h = eff_dim(cfg_height, MAX_H);
        c = col_pos;
        r = row_pos;
        top = '0;
        mid = '0;
        row_end = (c + 1 >= w);
        frame_end = (r + 1 >= h);
        res = '0;
        if (c < MAX_W) begin
            top = upper_row[c];
            mid = middle_row[c];
            upper_row[c] = mid;
            middle_row[c] = px;
        end
        hit = (c >= 2 && r >= 2);
        if (hit) begin
            win = '{prev2_col[0], prev1_col[0], top,
                    prev2_col[1], prev1_col[1], mid,
                    prev2_col[2], prev1_col[2], px};
            sum = 0;
            for (int k = 0; k < WIN_N; k++) sum += int'(win[k]);
            for (int k = 0; k < WIN_N; k++)
                res.code[k] = (9 * int'(win[k]) > sum);
            res.row = POS_W'(r - 1);
            res.col = POS_W'(c - 1);
            res.last = row_end && frame_end;
        end
        prev2_col = prev1_col;
        prev1_col = '{top, mid, px};
        if (row_end) begin
            col_pos = 0;
            row_pos = frame_end ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
        return hit;
    endfunction

    // entered and left at a falling edge
    task automatic send_pixel(input t_pix px, input bit typed = 1'b0,
                              input t_census want = '0);
        t_census got;
        while (!steady && $urandom_range(99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
        pixels_taken++;
        if (predict_census(px, got) && !typed) pending_codes.push_back(got);
        if (typed) pending_codes.push_back(want);
        @(negedge i_clk);
    endtask

    // registers change only with the pipe empty
    task automatic write_reg(input t_cfg_addr addr, input logic [CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_codes.size() != 0) @(negedge i_clk);
        repeat (PIPE_SLACK) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == CFG_IMAGE_WIDTH) cfg_width = value;
        else cfg_height = value;
    endtask

    // one frame from the origin back to the origin, optionally resized partway
    task automatic run_frame(input bit allow_change);
        int   style;
        int   split;
        int   n;
        int   v;
        t_pix base_px;
        style = $urandom_range(3);
        base_px = t_pix'($urandom_range(255));
        split = allow_change ?
            $urandom_range(eff_dim(cfg_width, MAX_W) * eff_dim(cfg_height, MAX_H) - 1, 1) : -1;
        n = 0;
        do begin
            if (n == split) begin
                // the width only shrinks, so no line store entry is read unwritten
                if ($urandom_range(1))
                    write_reg(CFG_IMAGE_HEIGHT, CFG_W'($urandom_range(10, 0)));
                else
                    write_reg(CFG_IMAGE_WIDTH,
                              CFG_W'($urandom_range(eff_dim(cfg_width, MAX_W), 0)));
            end
            case (style)
                0: v = $urandom_range(255);
                1: begin
                    v = int'(base_px) + int'($urandom_range(16)) - 8;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                end
                2: v = $urandom_range(1) ? 255 : 0;
                default: v = ($urandom_range(9) == 0) ? int'($urandom_range(255)) : base_px;
            endcase
            send_pixel(t_pix'(v));
            n++;
        end while (col_pos != 0 || row_pos != 0);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_census exp_code;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            codes_checked++;
            if (pending_codes.size() == 0) begin
                $error("unexpected result: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end else begin
                exp_code = pending_codes.pop_front();
                if (m_axis_tdata[8:0] !== exp_code.code) begin
                    $error("census_code expected %h got %h", exp_code.code, m_axis_tdata[8:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[18:9] !== exp_code.row) begin
                    $error("center_row expected %0d got %0d", exp_code.row, m_axis_tdata[18:9]);
                    mismatch_count++;
                end
                if (m_axis_tdata[28:19] !== exp_code.col) begin
                    $error("center_col expected %0d got %0d", exp_code.col, m_axis_tdata[28:19]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== exp_code.last) begin
                    $error("frame_last expected %b got %b", exp_code.last, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off to back the pipe up
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && codes_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= 11);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int base;
        int phase;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_REG)
                write_reg(directed_steps[i].addr, directed_steps[i].value);
            else
                send_pixel(t_pix'(directed_steps[i].value), directed_steps[i].typed,
                           directed_steps[i].want);
        end

        // widest row through an over-range width and an under-range height,
        // then the frame finishes narrow so the row wrap shows in the codes
        write_reg(CFG_IMAGE_WIDTH, 11'd2047);
        write_reg(CFG_IMAGE_HEIGHT, 11'd0);
        repeat (MAX_W) send_pixel(t_pix'($urandom_range(255)));
        write_reg(CFG_IMAGE_WIDTH, 11'd12);
        while (col_pos != 0 || row_pos != 0) send_pixel(t_pix'($urandom_range(255)));
        write_reg(CFG_IMAGE_HEIGHT, 11'd5);

        base = pixels_taken;
        phase = 0;
        while (pixels_taken - base < RANDOM_ITEMS) begin
            steady = (phase >= 2 && phase < 5);
            case ($urandom_range(3))
                0: begin
                    write_reg(CFG_IMAGE_WIDTH, CFG_W'(($urandom_range(7) == 0) ?
                              $urandom_range(2) : $urandom_range(12, 3)));
                    write_reg(CFG_IMAGE_HEIGHT, CFG_W'(($urandom_range(7) == 0) ?
                              $urandom_range(2) : $urandom_range(8, 3)));
                end
                1: write_reg(CFG_IMAGE_WIDTH, CFG_W'(($urandom_range(7) == 0) ?
                             $urandom_range(2) : $urandom_range(12, 3)));
                2: write_reg(CFG_IMAGE_HEIGHT, CFG_W'(($urandom_range(7) == 0) ?
                             $urandom_range(2) : $urandom_range(8, 3)));
                default: ;
            endcase
            repeat ($urandom_range(2, 1)) run_frame($urandom_range(4) == 0);
            phase++;
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
